@@ rtl/core/mafh_pkg.sv @@
// ----------------------------------------------------------------------------
// mafh_pkg
// Shared types, field codes and lookup tables for the audio frame header
// decoder pipeline.
// ----------------------------------------------------------------------------
package mafh_pkg;

    localparam int HDR_W   = 32;
    localparam int KBPS_W  = 9;
    localparam int MULT_W  = 18;
    localparam int NUM_W   = 26;
    localparam int QUOT_W  = 12;
    localparam int DIVS_W  = NUM_W + 1;
    localparam int RATE_W  = 16;
    localparam int SPF_W   = 11;
    localparam int BYTES_W = 12;

    // quotient bits resolved per divider stage, and the number of stages
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = QUOT_W / DIV_STEPS;

    localparam logic [10:0] SYNC_WORD = 11'h7FF;

    localparam logic [1:0] VER_MPEG1  = 2'b11;
    localparam logic [1:0] VER_MPEG2  = 2'b10;
    localparam logic [1:0] VER_MPEG25 = 2'b00;
    localparam logic [1:0] VER_RSVD   = 2'b01;

    localparam logic [1:0] LAY_I    = 2'b11;
    localparam logic [1:0] LAY_II   = 2'b10;
    localparam logic [1:0] LAY_III  = 2'b01;
    localparam logic [1:0] LAY_RSVD = 2'b00;

    localparam logic [3:0] BRI_BAD = 4'hF;
    localparam logic [1:0] SRI_BAD = 2'b11;

    localparam logic [1:0] FAM_V1  = 2'd0;
    localparam logic [1:0] FAM_V2  = 2'd1;
    localparam logic [1:0] FAM_V25 = 2'd2;

    localparam logic [2:0] ROW_V1L1  = 3'd0;
    localparam logic [2:0] ROW_V1L2  = 3'd1;
    localparam logic [2:0] ROW_V1L3  = 3'd2;
    localparam logic [2:0] ROW_V2L1  = 3'd3;
    localparam logic [2:0] ROW_V2L23 = 3'd4;

    localparam logic [MULT_W-1:0] MULT_L1    = 18'd12000;
    localparam logic [MULT_W-1:0] MULT_HALF  = 18'd72000;
    localparam logic [MULT_W-1:0] MULT_FULL  = 18'd144000;

    localparam logic [SPF_W-1:0] SPF_384  = 11'd384;
    localparam logic [SPF_W-1:0] SPF_576  = 11'd576;
    localparam logic [SPF_W-1:0] SPF_1152 = 11'd1152;

    // kbit/s by [row][bitrate index]; index 15 never reaches a valid word
    localparam logic [KBPS_W-1:0] KBPS_TAB [5][16] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    localparam logic [RATE_W-1:0] RATE_TAB [3][3] = '{
        '{16'd44100, 16'd48000, 16'd32000},
        '{16'd22050, 16'd24000, 16'd16000},
        '{16'd11025, 16'd12000, 16'd8000}
    };

    typedef struct packed {
        logic              hdr_ok;
        logic              layer1;
        logic              pad;
        logic [KBPS_W-1:0] kbps;
        logic [MULT_W-1:0] mult;
        logic [RATE_W-1:0] rate;
        logic [SPF_W-1:0]  samples;
    } t_dec;

    typedef struct packed {
        logic              hdr_ok;
        logic              layer1;
        logic              pad;
        logic [NUM_W-1:0]  rem;
        logic [DIVS_W-1:0] divs;
        logic [QUOT_W-1:0] quot;
        logic [RATE_W-1:0] rate;
        logic [SPF_W-1:0]  samples;
    } t_div;

endpackage

@@ rtl/core/mpeg_audio_frame_header_decode.sv @@
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_decode
// Audio frame header decoder: one header word in, one result word out.
// ----------------------------------------------------------------------------
// stages: decode, multiply, four 3-bit divider slices and an output register
// throughput: one word per cycle while the output is not stalled; every stage is
// a register
// empty stages are filled while the output is stalled
// reset clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
module mpeg_audio_frame_header_decode
    import mafh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [HDR_W-1:0]   i_header_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_header_valid,
    output logic [BYTES_W-1:0] o_frame_bytes,
    output logic [SPF_W-1:0]   o_samples_per_frame,
    output logic [RATE_W-1:0]  o_sample_rate_hz
);

    localparam int NSTG = DIV_STAGES + 3;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] adv;

    t_dec dec;
    t_div div_s [DIV_STAGES+1];

    logic               r_hv;
    logic [BYTES_W-1:0] r_bytes;
    logic [SPF_W-1:0]   r_spf;
    logic [RATE_W-1:0]  r_rate;
    logic [QUOT_W-1:0]  qp;

    // a stage loads when it is empty or its word moves on
    always_comb begin
        adv[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    mafh_decode u_decode (
        .i_clk         (i_clk),
        .i_en          (adv[0]),
        .i_header_word (i_header_word),
        .o_dec         (dec)
    );

    mafh_mul u_mul (
        .i_clk (i_clk),
        .i_en  (adv[1]),
        .i_dec (dec),
        .o_div (div_s[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        mafh_div_stage u_div (
            .i_clk (i_clk),
            .i_en  (adv[g+2]),
            .i_div (div_s[g]),
            .o_div (div_s[g+1])
        );
    end

    assign qp = div_s[DIV_STAGES].quot + {{(QUOT_W-1){1'b0}}, div_s[DIV_STAGES].pad};

    always_ff @(posedge i_clk) begin
        if (adv[NSTG-1]) begin
            r_hv    <= div_s[DIV_STAGES].hdr_ok;
            r_spf   <= div_s[DIV_STAGES].samples;
            r_rate  <= div_s[DIV_STAGES].rate;
            if (!div_s[DIV_STAGES].hdr_ok) begin
                r_bytes <= '0;
            end else if (div_s[DIV_STAGES].layer1) begin
                // layer I counts four-byte slots
                r_bytes <= {qp[BYTES_W-3:0], 2'b00};
            end else begin
                r_bytes <= qp[BYTES_W-1:0];
            end
        end
    end

    assign o_valid             = r_v[NSTG-1];
    assign o_header_valid      = r_hv;
    assign o_frame_bytes       = r_bytes;
    assign o_samples_per_frame = r_spf;
    assign o_sample_rate_hz    = r_rate;

endmodule

@@ rtl/core/mafh_decode.sv @@
// ----------------------------------------------------------------------------
// mafh_decode
// Sync check and table decode of one header word into a registered record.
// ----------------------------------------------------------------------------
module mafh_decode
    import mafh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [HDR_W-1:0] i_header_word,
    output t_dec             o_dec
);

    t_dec r_dec;
    t_dec n_dec;

    always_comb begin
        logic [1:0] ver;
        logic [1:0] lay;
        logic [3:0] bri;
        logic [1:0] sri;
        logic [1:0] fam;
        logic [2:0] row;
        logic       ok;

        ver = i_header_word[20:19];
        lay = i_header_word[18:17];
        bri = i_header_word[15:12];
        sri = i_header_word[11:10];
        ok  = (i_header_word[31:21] == SYNC_WORD) && (ver != VER_RSVD) &&
              (lay != LAY_RSVD) && (bri != BRI_BAD) && (sri != SRI_BAD);

        fam = (ver == VER_MPEG1) ? FAM_V1 : (ver == VER_MPEG2) ? FAM_V2 : FAM_V25;
        if (fam == FAM_V1) begin
            row = (lay == LAY_I) ? ROW_V1L1 : (lay == LAY_II) ? ROW_V1L2 : ROW_V1L3;
        end else begin
            row = (lay == LAY_I) ? ROW_V2L1 : ROW_V2L23;
        end

        n_dec         = '0;
        n_dec.hdr_ok  = ok;
        n_dec.layer1  = (lay == LAY_I);
        n_dec.pad     = i_header_word[9];
        if (ok) begin
            n_dec.kbps = KBPS_TAB[row][bri];
            n_dec.rate = RATE_TAB[fam][sri];
            priority if (lay == LAY_I) begin
                n_dec.samples = SPF_384;
                n_dec.mult    = MULT_L1;
            end else if (lay == LAY_III && fam != FAM_V1) begin
                n_dec.samples = SPF_576;
                n_dec.mult    = MULT_HALF;
            end else begin
                n_dec.samples = SPF_1152;
                n_dec.mult    = MULT_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_dec = r_dec;

endmodule

@@ rtl/core/mafh_mul.sv @@
// ----------------------------------------------------------------------------
// mafh_mul
// Forms the dividend (coefficient times kbit/s) and seeds the divider record.
// ----------------------------------------------------------------------------
module mafh_mul
    import mafh_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_dec i_dec,
    output t_div o_div
);

    t_div r_div;
    t_div n_div;

    always_comb begin
        logic [KBPS_W+MULT_W-1:0] prod;

        prod            = i_dec.kbps * i_dec.mult;
        n_div.hdr_ok    = i_dec.hdr_ok;
        n_div.layer1    = i_dec.layer1;
        n_div.pad       = i_dec.pad;
        // dividend never exceeds 26 bits for legal table values
        n_div.rem       = prod[NUM_W-1:0];
        // divisor aligned with the top quotient bit
        n_div.divs      = {i_dec.rate, {(DIVS_W-RATE_W){1'b0}}};
        n_div.quot      = '0;
        n_div.rate      = i_dec.rate;
        n_div.samples   = i_dec.samples;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

@@ rtl/core/mafh_div_stage.sv @@
// ----------------------------------------------------------------------------
// mafh_div_stage
// One slice of the restoring divider: resolves DIV_STEPS quotient bits and
// shifts the divisor right by the same amount.
// ----------------------------------------------------------------------------
module mafh_div_stage
    import mafh_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_div,
    output t_div o_div
);

    t_div r_div;
    t_div n_div;

    always_comb begin
        n_div = i_div;
        for (int j = 0; j < DIV_STEPS; j++) begin
            if ({1'b0, n_div.rem} >= n_div.divs) begin
                n_div.rem  = n_div.rem - n_div.divs[NUM_W-1:0];
                n_div.quot = {n_div.quot[QUOT_W-2:0], 1'b1};
            end else begin
                n_div.quot = {n_div.quot[QUOT_W-2:0], 1'b0};
            end
            n_div.divs = n_div.divs >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

@@ rtl/core/mafh_checker.sv @@
// ----------------------------------------------------------------------------
// mafh_checker
// Port-level checks on the header decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mafh_checker
    import mafh_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_header_valid,
    input logic [BYTES_W-1:0] o_frame_bytes,
    input logic [SPF_W-1:0]   o_samples_per_frame,
    input logic [RATE_W-1:0]  o_sample_rate_hz
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_bytes) &&
        $stable(o_header_valid) && $stable(o_sample_rate_hz))
        else $error("stalled result word changed");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_header_valid |->
        o_frame_bytes == '0 && o_samples_per_frame == '0 && o_sample_rate_hz == '0)
        else $error("rejected header with nonzero fields");

    a_spf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_header_valid |->
        (o_samples_per_frame == SPF_384 || o_samples_per_frame == SPF_576 ||
         o_samples_per_frame == SPF_1152) && o_sample_rate_hz != '0)
        else $error("illegal samples per frame or rate");

    // an empty pipeline never pushes back
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind mpeg_audio_frame_header_decode mafh_checker u_mafh_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_header_valid      (o_header_valid),
    .o_frame_bytes       (o_frame_bytes),
    .o_samples_per_frame (o_samples_per_frame),
    .o_sample_rate_hz    (o_sample_rate_hz)
);

@@ dv/mpeg_audio_frame_header_decode_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_decode_tb
// Drives header words through the decoder and checks each result word
// against a behavioural decode of sync, version, layer, bitrate, sample rate
// and padding. Directed corner headers come first, then mostly well-formed
// random headers mixed with broken and noise words, under random idling and stalls.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_header_decode_tb;
    import mafh_pkg::*;

    localparam int N_RANDOM       = 1930;
    localparam int CALM_TAIL      = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_WAIT       = 20;
    localparam int LONG_HOLD      = 60;
    localparam int LONG_HOLD_AT   = 500;
    localparam int MID_DRAIN_AT   = 1000;

    // kbit/s per table row: V1L1, V1L2, V1L3, V2L1, V2L2/3
    localparam int unsigned KBPS_BY_ROW [5][15] = '{
        '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
        '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
    };

    localparam int unsigned HZ_BY_FAMILY [3][3] = '{
        '{44100, 48000, 32000},
        '{22050, 24000, 16000},
        '{11025, 12000, 8000}
    };

    typedef struct packed {
        logic               ok;
        logic [BYTES_W-1:0] bytes;
        logic [SPF_W-1:0]   spf;
        logic [RATE_W-1:0]  hz;
    } t_frame_info;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [HDR_W-1:0]   i_header_word = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_header_valid;
    logic [BYTES_W-1:0] o_frame_bytes;
    logic [SPF_W-1:0]   o_samples_per_frame;
    logic [RATE_W-1:0]  o_sample_rate_hz;

    logic [HDR_W-1:0] header_q[$];
    t_frame_info      frame_info_q[$];

    int n_fail = 0;
    int n_directed = 0;
    int n_sent = 0;
    int n_frames = 0;
    int drained_at = -1;
    int gap_left = 0;
    int hold_left = 0;
    int burst_left = 0;
    int stuck = 0;
    int unsigned cyc = 0;
    bit long_hold_done = 1'b0;
    bit stall_next;

    mpeg_audio_frame_header_decode dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_header_word      (i_header_word),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_header_valid     (o_header_valid),
        .o_frame_bytes      (o_frame_bytes),
        .o_samples_per_frame(o_samples_per_frame),
        .o_sample_rate_hz   (o_sample_rate_hz)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_frame_info decode_frame_info(logic [HDR_W-1:0] w);
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [3:0]  bri;
        logic [1:0]  sri;
        int unsigned pad;
        int unsigned fam;
        int unsigned row;
        int unsigned kbps;
        int unsigned hz;
        int unsigned spf;
        int unsigned len;
        t_frame_info info;
        ver  = w[20:19];
        lay  = w[18:17];
        bri  = w[15:12];
        sri  = w[11:10];
        pad  = {31'd0, w[9]};
        info = '0;
        if (w[31:21] != SYNC_WORD || ver == VER_RSVD || lay == LAY_RSVD ||
            bri == BRI_BAD || sri == SRI_BAD) begin
            return info;
        end
        fam = (ver == VER_MPEG1) ? 0 : (ver == VER_MPEG2) ? 1 : 2;
        if (lay == LAY_I) begin
            row = (fam == 0) ? 0 : 3;
        end else if (fam == 0) begin
            row = (lay == LAY_II) ? 1 : 2;
        end else begin
            row = 4;
        end
        kbps = KBPS_BY_ROW[row][bri];
        hz   = HZ_BY_FAMILY[fam][sri];
        if (lay == LAY_I) begin
            spf = 384;
            len = (12 * kbps * 1000 / hz + pad) * 4;
        end else if (lay == LAY_III && fam != 0) begin
            // lower-rate layer iii carries half the samples
            spf = 576;
            len = 72 * kbps * 1000 / hz + pad;
        end else begin
            spf = 1152;
            len = 144 * kbps * 1000 / hz + pad;
        end
        info.ok    = 1'b1;
        info.bytes = len[BYTES_W-1:0];
        info.spf   = spf[SPF_W-1:0];
        info.hz    = hz[RATE_W-1:0];
        return info;
    endfunction

    function automatic logic [HDR_W-1:0] build_header(logic [1:0] ver, logic [1:0] lay,
                                                      logic [3:0] bri, logic [1:0] sri,
                                                      logic pad, logic [HDR_W-1:0] filler);
        return {SYNC_WORD, ver, lay, filler[16], bri, sri, pad, filler[8:0]};
    endfunction

    function automatic logic [HDR_W-1:0] random_header();
        logic [1:0] ver;
        logic [1:0] lay;
        logic [HDR_W-1:0] w;
        int pick;
        case ($urandom_range(0, 2))
            0: ver = VER_MPEG1;
            1: ver = VER_MPEG2;
            default: ver = VER_MPEG25;
        endcase
        case ($urandom_range(0, 2))
            0: lay = LAY_I;
            1: lay = LAY_II;
            default: lay = LAY_III;
        endcase
        w = build_header(ver, lay, 4'($urandom_range(0, 14)), 2'($urandom_range(0, 2)),
                         1'($urandom_range(0, 1)), $urandom);
        pick = $urandom_range(0, 99);
        if (pick >= 90) begin
            w = $urandom;
        end else if (pick >= 75) begin
            // break exactly one part of an otherwise good word
            case ($urandom_range(0, 4))
                0: w[21 + $urandom_range(0, 10)] = 1'b0;
                1: w[20:19] = VER_RSVD;
                2: w[18:17] = LAY_RSVD;
                3: w[15:12] = BRI_BAD;
                default: w[11:10] = SRI_BAD;
            endcase
        end
        return w;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                frame_info_q.push_back(decode_frame_info(i_header_word));
            end
            if (!i_valid || !o_stall) begin
                if ((n_sent == n_directed || n_sent == MID_DRAIN_AT) && drained_at != n_sent &&
                    header_q.size() != 0) begin
                    // hold off until every outstanding result is back
                    if (frame_info_q.size() == 0) begin
                        drained_at = n_sent;
                    end
                    i_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (header_q.size() >= CALM_TAIL && ((cyc >> 8) % 3) != 2 &&
                             $urandom_range(0, 99) < 15) begin
                    gap_left = $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else if (header_q.size() != 0) begin
                    i_valid       <= 1'b1;
                    i_header_word <= header_q.pop_front();
                    n_sent = n_sent + 1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (frame_info_q.size() == 0) begin
                    $error("unexpected result word: header_valid %0d frame_bytes %0d",
                           o_header_valid, o_frame_bytes);
                    n_fail = n_fail + 1;
                end else begin
                    t_frame_info want;
                    want = frame_info_q.pop_front();
                    n_frames = n_frames + 1;
                    if (o_header_valid !== want.ok) begin
                        $error("header_valid: expected %0d, actual %0d", want.ok,
                               o_header_valid);
                        n_fail = n_fail + 1;
                    end
                    if (o_frame_bytes !== want.bytes) begin
                        $error("frame_bytes: expected %0d, actual %0d", want.bytes,
                               o_frame_bytes);
                        n_fail = n_fail + 1;
                    end
                    if (o_samples_per_frame !== want.spf) begin
                        $error("samples_per_frame: expected %0d, actual %0d", want.spf,
                               o_samples_per_frame);
                        n_fail = n_fail + 1;
                    end
                    if (o_sample_rate_hz !== want.hz) begin
                        $error("sample_rate_hz: expected %0d, actual %0d", want.hz,
                               o_sample_rate_hz);
                        n_fail = n_fail + 1;
                    end
                end
            end
            stall_next = 1'b0;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                stall_next = 1'b1;
            end else if (!long_hold_done && n_frames >= LONG_HOLD_AT) begin
                // long hold so the pipeline fills and pushes back on the sender
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                stall_next = 1'b1;
            end else if (burst_left > 0) begin
                burst_left = burst_left - 1;
                stall_next = 1'b1;
            end else if (header_q.size() >= CALM_TAIL && ((cyc >> 8) % 4) != 1 &&
                         $urandom_range(0, 99) < 12) begin
                burst_left = $urandom_range(0, 7);
                stall_next = 1'b1;
            end
            i_stall <= stall_next;
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        // directed corners: table entries, mostly extremes, per version and layer
        header_q.push_back(build_header(VER_MPEG1, LAY_I, 4'd14, 2'd2, 1'b1, '0));
        header_q.push_back(build_header(VER_MPEG1, LAY_II, 4'd14, 2'd2, 1'b0, '1));
        header_q.push_back(build_header(VER_MPEG1, LAY_III, 4'd1, 2'd0, 1'b1, '0));
        header_q.push_back(build_header(VER_MPEG1, LAY_III, 4'd14, 2'd1, 1'b0, '0));
        header_q.push_back(build_header(VER_MPEG2, LAY_I, 4'd9, 2'd1, 1'b0, '0));
        header_q.push_back(build_header(VER_MPEG2, LAY_II, 4'd14, 2'd2, 1'b1, '0));
        header_q.push_back(build_header(VER_MPEG2, LAY_III, 4'd8, 2'd0, 1'b1, '1));
        header_q.push_back(build_header(VER_MPEG25, LAY_I, 4'd14, 2'd2, 1'b1, '0));
        header_q.push_back(build_header(VER_MPEG25, LAY_II, 4'd14, 2'd2, 1'b1, '0));
        header_q.push_back(build_header(VER_MPEG25, LAY_III, 4'd1, 2'd0, 1'b0, '0));
        header_q.push_back(build_header(VER_MPEG25, LAY_III, 4'd14, 2'd1, 1'b1, '1));
        // free format
        header_q.push_back(build_header(VER_MPEG1, LAY_I, 4'd0, 2'd0, 1'b1, '0));
        header_q.push_back(build_header(VER_MPEG1, LAY_II, 4'd0, 2'd1, 1'b1, '0));
        header_q.push_back(build_header(VER_MPEG2, LAY_III, 4'd0, 2'd2, 1'b0, '0));
        // sync missing
        header_q.push_back('0);
        header_q.push_back(build_header(VER_MPEG1, LAY_II, 4'd5, 2'd0, 1'b0, '0) &
                           ~(32'd1 << 21));
        header_q.push_back(build_header(VER_MPEG1, LAY_II, 4'd5, 2'd0, 1'b0, '0) &
                           ~(32'd1 << 31));
        // reserved codes
        header_q.push_back(build_header(VER_RSVD, LAY_II, 4'd5, 2'd0, 1'b0, '0));
        header_q.push_back(build_header(VER_MPEG1, LAY_RSVD, 4'd5, 2'd0, 1'b0, '0));
        header_q.push_back(build_header(VER_MPEG1, LAY_II, BRI_BAD, 2'd0, 1'b0, '0));
        header_q.push_back(build_header(VER_MPEG2, LAY_I, 4'd5, SRI_BAD, 1'b1, '0));
        header_q.push_back('1);
        n_directed = header_q.size();
        for (int k = 0; k < N_RANDOM; k++) begin
            header_q.push_back(random_header());
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stuck < WATCHDOG_LIMIT &&
               (header_q.size() != 0 || i_valid || frame_info_q.size() != 0)) begin
            @(posedge i_clk);
        end
        if (stuck >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
        end else begin
            repeat (END_WAIT) @(posedge i_clk);
            if (n_fail == 0 && frame_info_q.size() == 0) begin
                $display("All tests passed");
            end else begin
                $display("Some tests failed");
            end
        end
        $finish;
    end

endmodule
